// ----- hdl/cosol_pkg.sv -----
// Shared types, codes and default sizes for the count-ordered self-organizing list.
package cosol_pkg;

	// Default sizes handed to the top level parameters.
	localparam int DEPTH_DEF      = 16;
	localparam int KEY_BITS_DEF   = 64;
	localparam int COUNT_BITS_DEF = 16;

	// Fixed widths of the transaction fields.
	localparam int KEY_W    = 64;
	localparam int POS_W    = 4;
	localparam int HIT_W    = 16;
	localparam int STATUS_W = 2;

	// Request codes.
	typedef enum logic {
		REQ_ADD    = 1'b0,
		REQ_SEARCH = 1'b1
	} req_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WALK,
		S_PLACE,
		S_FIN
	} state_t;

endpackage

// ----- hdl/count_ordered_self_organizing_list.sv -----
// Top level of the count-ordered self-organizing list: sequencer, fill level and result register.
// The block keeps up to DEPTH keys ordered by access count, highest first, in a table with
// one read and one write port. It takes one request at a time and holds in_stall high until
// that request's result has been loaded into the output register. An add, or any request
// that is answered at once (table full, search on an empty table), goes from idle straight
// to the finishing state, which loads the output register once it is free. A search scans
// from the head at one entry per cycle, then walks back from the hit toward the head, moving
// each passed entry down by one slot per cycle, and finally writes the promoted entry. A hit
// at the head skips the walk and goes straight to the write; a miss ends the scan at the
// fill level.
module count_ordered_self_organizing_list #(
	parameter int DEPTH      = cosol_pkg::DEPTH_DEF,
	parameter int KEY_BITS   = cosol_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS = cosol_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [cosol_pkg::KEY_W-1:0]   key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cosol_pkg::STATUS_W-1:0] status,
	output logic [cosol_pkg::POS_W-1:0]   old_position,
	output logic [cosol_pkg::POS_W-1:0]   new_position,
	output logic [cosol_pkg::HIT_W-1:0]   hit_count
);

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	cosol_pkg::state_t state_q, state_d;

	logic [FILL_W-1:0]     fill_q;
	logic [FILL_W-1:0]     scan_q;
	logic                  look_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [IDX_W-1:0]      ptr_q;
	logic [IDX_W-1:0]      cmp_q;
	logic [IDX_W-1:0]      pos_q;
	logic [IDX_W-1:0]      dst_q;
	logic [COUNT_BITS-1:0] cnt_q;

	cosol_pkg::status_t    res_status_q;
	logic [IDX_W-1:0]      res_old_q;
	logic [IDX_W-1:0]      res_new_q;
	logic [COUNT_BITS-1:0] res_cnt_q;

	logic                  out_valid_q;
	cosol_pkg::status_t    out_status_q;
	logic [IDX_W-1:0]      out_old_q;
	logic [IDX_W-1:0]      out_new_q;
	logic [COUNT_BITS-1:0] out_cnt_q;

	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [KEY_BITS-1:0]   wr_key;
	logic [COUNT_BITS-1:0] wr_cnt;
	logic [IDX_W-1:0]      rd_addr;
	logic [KEY_BITS-1:0]   rd_key;
	logic [COUNT_BITS-1:0] rd_cnt;

	logic                  accept_in;
	logic                  is_search;
	logic                  is_full;
	logic                  key_hit;
	logic                  walk_move;
	logic                  out_free;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [FILL_W-1:0]     hit_pos;

	cosol_table #(
		.DEPTH      (DEPTH),
		.KEY_BITS   (KEY_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_cnt  (wr_cnt),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_cnt  (rd_cnt)
	);

	// Shared decode of the current cycle.
	assign accept_in = in_valid && !in_stall;
	assign is_search = (req_type == cosol_pkg::REQ_SEARCH);
	assign is_full   = (fill_q == FILL_W'(DEPTH));
	assign key_hit   = look_q && (rd_key == key_q);
	assign walk_move = look_q && (rd_cnt <= cnt_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign cnt_inc   = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
	assign hit_pos   = scan_q - FILL_W'(1);

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cosol_pkg::S_IDLE: begin
				if (accept_in) begin
					if (is_search && (fill_q != '0)) begin
						state_d = cosol_pkg::S_SCAN;
					end else begin
						state_d = cosol_pkg::S_FIN;
					end
				end
			end
			cosol_pkg::S_SCAN: begin
				if (key_hit) begin
					state_d = (hit_pos == '0) ? cosol_pkg::S_PLACE : cosol_pkg::S_WALK;
				end else if (scan_q == fill_q) begin
					state_d = cosol_pkg::S_FIN;
				end
			end
			cosol_pkg::S_WALK: begin
				if (look_q && (!walk_move || (cmp_q == '0))) begin
					state_d = cosol_pkg::S_PLACE;
				end
			end
			cosol_pkg::S_PLACE: begin
				state_d = cosol_pkg::S_FIN;
			end
			cosol_pkg::S_FIN: begin
				if (out_free) begin
					state_d = cosol_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cosol_pkg::S_IDLE;
			end
		endcase
	end

	// Table port controls and input stall for each state.
	always_comb begin
		in_stall = 1'b1;
		wr_en    = 1'b0;
		wr_addr  = dst_q;
		wr_key   = key_q;
		wr_cnt   = cnt_q;
		rd_addr  = ptr_q;
		unique case (state_q)
			cosol_pkg::S_IDLE: begin
				in_stall = 1'b0;
				wr_en    = accept_in && !is_search && !is_full;
				wr_addr  = fill_q[IDX_W-1:0];
				wr_key   = key[KEY_BITS-1:0];
				wr_cnt   = '0;
			end
			cosol_pkg::S_SCAN: begin
				rd_addr = scan_q[IDX_W-1:0];
			end
			cosol_pkg::S_WALK: begin
				wr_en   = walk_move;
				wr_addr = cmp_q + IDX_W'(1);
				wr_key  = rd_key;
				wr_cnt  = rd_cnt;
			end
			cosol_pkg::S_PLACE: begin
				wr_en = 1'b1;
			end
			cosol_pkg::S_FIN: begin
				in_stall = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cosol_pkg::S_IDLE;
			fill_q      <= '0;
			look_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept_in && !is_search && !is_full) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			unique case (state_q)
				cosol_pkg::S_IDLE:  look_q <= 1'b0;
				cosol_pkg::S_SCAN:  look_q <= !key_hit;
				cosol_pkg::S_WALK:  look_q <= 1'b1;
				cosol_pkg::S_PLACE: look_q <= 1'b0;
				cosol_pkg::S_FIN:   look_q <= 1'b0;
				default:            look_q <= 1'b0;
			endcase
			if ((state_q == cosol_pkg::S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sequencer datapath: scan pointer, walk pointers and pending result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			cosol_pkg::S_IDLE: begin
				key_q  <= key[KEY_BITS-1:0];
				scan_q <= '0;
				dst_q  <= '0;
				if (is_search) begin
					res_status_q <= cosol_pkg::ST_NOT_FOUND;
					res_old_q    <= '0;
					res_new_q    <= '0;
				end else if (is_full) begin
					res_status_q <= cosol_pkg::ST_FULL;
					res_old_q    <= '0;
					res_new_q    <= '0;
				end else begin
					res_status_q <= cosol_pkg::ST_OK;
					res_old_q    <= fill_q[IDX_W-1:0];
					res_new_q    <= fill_q[IDX_W-1:0];
				end
				res_cnt_q <= '0;
			end
			cosol_pkg::S_SCAN: begin
				// A hit starts the walk at the entry just ahead of it.
				if (key_hit) begin
					pos_q <= hit_pos[IDX_W-1:0];
					ptr_q <= hit_pos[IDX_W-1:0] - IDX_W'(1);
					cnt_q <= cnt_inc;
				end else begin
					scan_q <= scan_q + FILL_W'(1);
				end
			end
			cosol_pkg::S_WALK: begin
				// Entries at or below the new count move down; the first higher one stops the walk.
				if (look_q) begin
					dst_q <= walk_move ? cmp_q : cmp_q + IDX_W'(1);
				end else begin
					dst_q <= pos_q;
				end
				cmp_q <= ptr_q;
				ptr_q <= ptr_q - IDX_W'(1);
			end
			cosol_pkg::S_PLACE: begin
				res_status_q <= cosol_pkg::ST_OK;
				res_old_q    <= pos_q;
				res_new_q    <= dst_q;
				res_cnt_q    <= cnt_q;
			end
			cosol_pkg::S_FIN: begin
				key_q <= key_q;
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

	// Output register, loaded when the finished result can be handed over.
	always_ff @(posedge clk) begin
		if ((state_q == cosol_pkg::S_FIN) && out_free) begin
			out_status_q <= res_status_q;
			out_old_q    <= res_old_q;
			out_new_q    <= res_new_q;
			out_cnt_q    <= res_cnt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign old_position = cosol_pkg::POS_W'(out_old_q);
	assign new_position = cosol_pkg::POS_W'(out_new_q);
	assign hit_count    = cosol_pkg::HIT_W'(out_cnt_q);

endmodule

// ----- hdl/cosol_table.sv -----
// Entry storage for the list: key and count arrays with one write port and one registered read port.
module cosol_table #(
	parameter int DEPTH      = cosol_pkg::DEPTH_DEF,
	parameter int KEY_BITS   = cosol_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS = cosol_pkg::COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [KEY_BITS-1:0]      wr_key,
	input  logic [COUNT_BITS-1:0]    wr_cnt,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [KEY_BITS-1:0]      rd_key,
	output logic [COUNT_BITS-1:0]    rd_cnt
);

	logic [KEY_BITS-1:0]   key_mem [DEPTH];
	logic [COUNT_BITS-1:0] cnt_mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			cnt_mem[wr_addr] <= wr_cnt;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		rd_key <= key_mem[rd_addr];
		rd_cnt <= cnt_mem[rd_addr];
	end

endmodule
